/* src/two_region_page_allocator_core_assert.svh */
// Assertion macros used by the page allocator checker tpa_checker.
`ifndef TWO_REGION_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define TWO_REGION_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define TPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define TPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

/* src/tpa_pkg.sv */
`default_nettype none
package tpa_pkg;

    localparam int ADDR_W    = 40;
    localparam int CNT_W     = 13;
    localparam int STATUS_W  = 3;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_MAX   = 2**CNT_W - 1;

    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_PAGE_BYTES = 4096;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_INIT  = 2'd0;
    localparam t_cmd CMD_ALLOC = 2'd1;
    localparam t_cmd CMD_FREE  = 2'd2;
    localparam t_cmd CMD_NOP   = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_OOM       = 3'd1;
    localparam t_status ST_MISALIGN  = 3'd2;
    localparam t_status ST_OUTSIDE   = 3'd3;
    localparam t_status ST_OVERFLOW  = 3'd4;

    localparam t_cfg_idx CFG_BASE_ADDR  = 2'd0;
    localparam t_cfg_idx CFG_KERN_PAGES = 2'd1;
    localparam t_cfg_idx CFG_USER_PAGES = 2'd2;

    localparam logic [CNT_W-1:0] RST_KERN_PAGES = 13'd1024;
    localparam logic [CNT_W-1:0] RST_USER_PAGES = 13'd3072;

endpackage
`default_nettype wire

/* src/tpa_ram.sv */
`default_nettype none
module tpa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/tpa_geom.sv */
`default_nettype none
module tpa_geom #(
    parameter int MAX_PAGES  = tpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = tpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic [tpa_pkg::ADDR_W-1:0]        i_base_addr,
    input  wire logic [tpa_pkg::CNT_W-1:0]         i_krnl_pages,
    input  wire logic [tpa_pkg::CNT_W-1:0]         i_user_pages,
    input  wire logic                              i_kern,
    output logic      [$clog2(MAX_PAGES+1)-1:0]    o_size,
    output logic      [$clog2(MAX_PAGES+1)-1:0]    o_slot0,
    output logic      [tpa_pkg::ADDR_W+1:0]        o_begin,
    output logic      [tpa_pkg::ADDR_W+1:0]        o_end
);
    import tpa_pkg::*;

    localparam int CW       = $clog2(MAX_PAGES+1);
    localparam int EW       = ADDR_W + 2;
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);

    logic [CW-1:0] ksz;
    logic [CW-1:0] room;
    logic [CW-1:0] usz;
    logic [EW-1:0] region_off;

    // kernel region clipped to the page pool, user region to what is left
    assign ksz  = (i_krnl_pages < MAX_PAGES) ? CW'(i_krnl_pages) : CW'(MAX_PAGES);
    assign room = CW'(MAX_PAGES) - ksz;
    assign usz  = (i_user_pages < room) ? CW'(i_user_pages) : room;

    assign o_size     = i_kern ? ksz : usz;
    assign o_slot0    = i_kern ? '0 : ksz;
    assign region_off = i_kern ? '0 : (EW'(ksz) << PB_SHIFT);
    assign o_begin    = EW'(i_base_addr) + region_off;
    assign o_end      = o_begin + (EW'(o_size) << PB_SHIFT);

endmodule
`default_nettype wire

/* src/two_region_page_allocator_core.sv */
// Page allocator, kernel and user regions, one command per clock.
// The result strobe o_valid is high in the cycle right after accept.
// Throughput: one command every cycle; busy never rises, results cannot stall.
// Reset (sync, active low): stack counts and watermarks clear, config
// registers return to defaults; the stack RAM itself is never cleared.
`default_nettype none
module two_region_page_allocator_core #(
    parameter int MAX_PAGES  = tpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = tpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command transaction
    input  wire logic                          start,
    output logic                               busy,
    input  wire tpa_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_region_select,
    input  wire logic [tpa_pkg::ADDR_W-1:0]    i_page_addr,
    // result, one cycle per transaction
    output logic                               o_valid,
    output logic      [tpa_pkg::ADDR_W-1:0]    o_out_addr,
    output tpa_pkg::t_status                   o_status,
    output logic      [tpa_pkg::CNT_W-1:0]     o_free_count,
    // config write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire tpa_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [tpa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import tpa_pkg::*;

    localparam int CW       = $clog2(MAX_PAGES+1);  // counts up to MAX_PAGES
    localparam int SW       = CW + 1;               // slot sums
    localparam int IW       = $clog2(MAX_PAGES);    // stack RAM address / page index
    localparam int EW       = ADDR_W + 2;           // region bounds without wrap
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);

    // ---------------- config registers ----------------
    logic [ADDR_W-1:0] r_base_addr;
    logic [CNT_W-1:0]  r_krnl_pages;
    logic [CNT_W-1:0]  r_user_pages;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr  <= '0;
            r_krnl_pages <= RST_KERN_PAGES;
            r_user_pages <= RST_USER_PAGES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDR:  r_base_addr  <= i_cfg_data;
                CFG_KERN_PAGES: r_krnl_pages <= i_cfg_data[CNT_W-1:0];
                CFG_USER_PAGES: r_user_pages <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- region geometry ----------------
    logic [CW-1:0] size;
    logic [CW-1:0] slot0;
    logic [EW-1:0] rgn_begin;
    logic [EW-1:0] rgn_end;

    tpa_geom #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_geom (
        .i_base_addr  (r_base_addr),
        .i_krnl_pages (r_krnl_pages),
        .i_user_pages (r_user_pages),
        .i_kern       (i_region_select),
        .o_size       (size),
        .o_slot0      (slot0),
        .o_begin      (rgn_begin),
        .o_end        (rgn_end)
    );

    // ---------------- allocator state ----------------
    // Per region: stack count (freed pages waiting) and fresh watermark.
    logic [CW-1:0] r_kstack, r_ustack, r_kfresh, r_ufresh;
    logic          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic [CW-1:0] stack, fresh;
    assign stack = i_region_select ? r_kstack : r_ustack;
    assign fresh = i_region_select ? r_kfresh : r_ufresh;

    logic [SW-1:0] push_slot, pop_slot;
    assign push_slot = SW'(slot0) + SW'(stack);
    assign pop_slot  = push_slot - SW'(1);

    logic              misaligned, outside, overflow;
    logic [EW-1:0]     page_ext;
    logic [EW-1:0]     page_off;
    logic [EW-1:0]     fresh_addr;

    assign page_ext   = EW'(i_page_addr);
    assign misaligned = |i_page_addr[PB_SHIFT-1:0];
    assign outside    = (page_ext < rgn_begin) || (page_ext >= rgn_end);
    // a free with nothing out, or one past the pool, is a double free
    assign overflow   = (stack >= fresh) || (push_slot >= MAX_PAGES);
    assign page_off   = (page_ext - rgn_begin) >> PB_SHIFT;
    assign fresh_addr = rgn_begin + (EW'(fresh) << PB_SHIFT);

    // ---------------- command decode ----------------
    logic [CW-1:0]     n_stack, n_fresh;
    logic              clear_all;
    logic              ram_we_c, ram_re_c, pop_c;
    t_status           status_c;
    logic [ADDR_W-1:0] addr_base_c;

    always_comb begin
        n_stack     = stack;
        n_fresh     = fresh;
        clear_all   = 1'b0;
        ram_we_c    = 1'b0;
        ram_re_c    = 1'b0;
        pop_c       = 1'b0;
        status_c    = ST_OK;
        addr_base_c = '0;
        unique case (i_cmd)
            CMD_INIT: begin
                clear_all = 1'b1;
            end
            CMD_ALLOC: begin
                if (stack != '0) begin
                    // pop; a slot past the pool reads as page index zero
                    n_stack     = stack - CW'(1);
                    ram_re_c    = (pop_slot < MAX_PAGES);
                    pop_c       = ram_re_c;
                    addr_base_c = rgn_begin[ADDR_W-1:0];
                end else if (fresh < size) begin
                    n_fresh     = fresh + CW'(1);
                    addr_base_c = fresh_addr[ADDR_W-1:0];
                end else begin
                    status_c = ST_OOM;
                end
            end
            CMD_FREE: begin
                if (misaligned) begin
                    status_c = ST_MISALIGN;
                end else if (outside) begin
                    status_c = ST_OUTSIDE;
                end else if (overflow) begin
                    status_c = ST_OVERFLOW;
                end else begin
                    ram_we_c = 1'b1;
                    n_stack  = stack + CW'(1);
                end
            end
            CMD_NOP: ;
            default: ;
        endcase
    end

    // allocatable pages in the selected region after this command
    logic [SW-1:0]    avail;
    logic [CNT_W-1:0] free_count_c;

    always_comb begin
        if (clear_all) begin
            avail = SW'(size);
        end else if (n_fresh < size) begin
            avail = SW'(n_stack) + SW'(size - n_fresh);
        end else begin
            avail = SW'(n_stack);
        end
        free_count_c = (avail > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(avail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kstack <= '0;
            r_ustack <= '0;
            r_kfresh <= '0;
            r_ufresh <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= accept;
            if (accept) begin
                if (clear_all) begin
                    r_kstack <= '0;
                    r_ustack <= '0;
                    r_kfresh <= '0;
                    r_ufresh <= '0;
                end else if (i_region_select) begin
                    r_kstack <= n_stack;
                    r_kfresh <= n_fresh;
                end else begin
                    r_ustack <= n_stack;
                    r_ufresh <= n_fresh;
                end
            end
        end
    end

    // ---------------- free stack RAM ----------------
    // Written at the accept edge of a free and read at the accept edge of an
    // alloc, so back-to-back free/alloc needs no bypass.
    logic [IW-1:0] ram_rdata;

    tpa_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (accept && ram_we_c),
        .i_waddr (push_slot[IW-1:0]),
        .i_wdata (page_off[IW-1:0]),
        .i_re    (accept && ram_re_c),
        .i_raddr (pop_slot[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- result register ----------------
    logic [ADDR_W-1:0] r_addr_base;
    logic              r_pop;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr_base  <= addr_base_c;
            r_pop        <= pop_c;
            o_status     <= status_c;
            o_free_count <= free_count_c;
        end
    end

    // popped page index lands from RAM in the result cycle
    assign o_out_addr = r_addr_base +
                        (r_pop ? (ADDR_W'(ram_rdata) << PB_SHIFT) : ADDR_W'(0));

endmodule
`default_nettype wire

/* src/tpa_checker.sv */
`default_nettype none
`include "two_region_page_allocator_core_assert.svh"
module tpa_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire logic [tpa_pkg::ADDR_W-1:0] o_out_addr,
    input wire tpa_pkg::t_status           o_status,
    input wire logic [tpa_pkg::CNT_W-1:0]  o_free_count
);
    import tpa_pkg::*;

    // every accepted command yields exactly one result, in the next cycle
    `TPA_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_valid)
    `TPA_ASSERT_IMP(a_no_stray_result, i_clk, i_rst_n, o_valid, $past(start && !busy))
    // failures never hand out an address
    `TPA_ASSERT_IMP(a_err_no_addr, i_clk, i_rst_n,
        o_valid && (o_status != ST_OK), o_out_addr == '0)
    // out of memory means nothing left in that region
    `TPA_ASSERT_IMP(a_oom_empty, i_clk, i_rst_n,
        o_valid && (o_status == ST_OOM), o_free_count == '0)

endmodule

bind two_region_page_allocator_core tpa_checker u_tpa_checker (.*);
`default_nettype wire

/* verif/page_allocator_checker.sv */
`timescale 1ns / 100ps
// Watches the command, result and config channels of the page allocator,
// keeps a shadow copy of the allocator state and compares every result.
module page_allocator_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_start,
    input  logic                           i_busy,
    input  tpa_pkg::t_cmd                  i_cmd,
    input  logic                           i_region_select,
    input  logic [tpa_pkg::ADDR_W-1:0]     i_page_addr,
    // result strobe
    input  logic                           i_res_valid,
    input  logic [tpa_pkg::ADDR_W-1:0]     i_res_addr,
    input  tpa_pkg::t_status               i_res_status,
    input  logic [tpa_pkg::CNT_W-1:0]      i_res_free_count,
    // config write channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  tpa_pkg::t_cfg_idx              i_cfg_index,
    input  logic [tpa_pkg::ADDR_W-1:0]     i_cfg_data,
    // to the testbench top
    output int                             o_fail_count,
    output int                             o_pending
);
    import tpa_pkg::*;

    localparam int unsigned MAX_PAGES  = DEF_MAX_PAGES;
    localparam int unsigned PAGE_BYTES = DEF_PAGE_BYTES;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [CNT_W-1:0]  free_cnt;
    } t_page_result;

    // shadow config
    logic [ADDR_W-1:0] base_addr;
    logic [CNT_W-1:0]  krnl_pages;
    logic [CNT_W-1:0]  user_pages;

    // shadow allocator state: freed page indices, stack depths, watermarks
    logic [11:0]       freed_pages [MAX_PAGES];
    int unsigned       kern_stack;
    int unsigned       user_stack;
    int unsigned       kern_mark;
    int unsigned       user_mark;

    t_page_result      expected_results [$];
    int                mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    task automatic apply_page_command(input t_cmd cmd, input logic kern,
                                      input logic [ADDR_W-1:0] page,
                                      output t_page_result res);
        int unsigned     ksz;
        int unsigned     room;
        int unsigned     size;
        int unsigned     slot0;
        int unsigned     slot;
        int unsigned     idx;
        int unsigned     stk;
        int unsigned     mark;
        int unsigned     avail;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned pg;
        longint unsigned addr;
        t_status         st;

        ksz   = (krnl_pages < MAX_PAGES) ? int'(krnl_pages) : MAX_PAGES;
        room  = MAX_PAGES - ksz;
        size  = kern ? ksz : ((user_pages < room) ? int'(user_pages) : room);
        slot0 = kern ? 0 : ksz;
        lo    = 64'(base_addr);
        if (!kern) begin
            lo = lo + 64'(ksz) * 64'(PAGE_BYTES);
        end
        hi    = lo + 64'(size) * 64'(PAGE_BYTES);
        stk   = kern ? kern_stack : user_stack;
        mark  = kern ? kern_mark : user_mark;
        pg    = 64'(page);
        addr  = 0;
        st    = ST_OK;

        case (cmd)
            CMD_INIT: begin
                kern_stack = 0;
                user_stack = 0;
                kern_mark  = 0;
                user_mark  = 0;
                stk        = 0;
                mark       = 0;
            end
            CMD_ALLOC: begin
                if (stk > 0) begin
                    // most recently freed page goes out first
                    slot = slot0 + stk - 1;
                    idx  = (slot < MAX_PAGES) ? int'(freed_pages[slot]) : 0;
                    addr = lo + 64'(idx) * 64'(PAGE_BYTES);
                    stk  = stk - 1;
                end else if (mark < size) begin
                    addr = lo + 64'(mark) * 64'(PAGE_BYTES);
                    mark = mark + 1;
                end else begin
                    st = ST_OOM;
                end
            end
            CMD_FREE: begin
                if (pg % 64'(PAGE_BYTES) != 0) begin
                    st = ST_MISALIGN;
                end else if (pg < lo || pg >= hi) begin
                    st = ST_OUTSIDE;
                end else begin
                    slot = slot0 + stk;
                    // more frees than pages handed out, or a slot past the pool
                    if (stk >= mark || slot >= MAX_PAGES) begin
                        st = ST_OVERFLOW;
                    end else begin
                        freed_pages[slot] = 12'((pg - lo) / 64'(PAGE_BYTES));
                        stk = stk + 1;
                    end
                end
            end
            default: ;
        endcase

        if (kern) begin
            kern_stack = stk;
            kern_mark  = mark;
        end else begin
            user_stack = stk;
            user_mark  = mark;
        end

        avail = stk + ((mark < size) ? size - mark : 0);
        if (avail > CNT_MAX) begin
            avail = CNT_MAX;
        end
        res.addr     = addr[ADDR_W-1:0];
        res.status   = st;
        res.free_cnt = avail[CNT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_page_result want;
        if (!i_rst_n) begin
            base_addr  = '0;
            krnl_pages = RST_KERN_PAGES;
            user_pages = RST_USER_PAGES;
            kern_stack = 0;
            user_stack = 0;
            kern_mark  = 0;
            user_mark  = 0;
            expected_results.delete();
        end else begin
            // result of an earlier transaction first, then this edge's command
            if (i_res_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ERROR result with nothing expected: addr %h status %0d count %0d",
                             $time, i_res_addr, i_res_status, i_res_free_count);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_addr !== want.addr) begin
                        $display("%0t ERROR out_addr: expected %h, actual %h",
                                 $time, want.addr, i_res_addr);
                        mismatches++;
                    end
                    if (i_res_status !== want.status) begin
                        $display("%0t ERROR status: expected %0d, actual %0d",
                                 $time, want.status, i_res_status);
                        mismatches++;
                    end
                    if (i_res_free_count !== want.free_cnt) begin
                        $display("%0t ERROR free_count: expected %0d, actual %0d",
                                 $time, want.free_cnt, i_res_free_count);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE_ADDR:  base_addr  = i_cfg_data;
                    CFG_KERN_PAGES: krnl_pages = i_cfg_data[CNT_W-1:0];
                    CFG_USER_PAGES: user_pages = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                apply_page_command(i_cmd, i_region_select, i_page_addr, want);
                expected_results.push_back(want);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

/* verif/two_region_page_allocator_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, config phases and command stimulus.
// Checking lives in page_allocator_checker and the bound tpa_checker; this
// module only drives the block and reports the verdict.
module two_region_page_allocator_core_tb;
    import tpa_pkg::*;

    localparam int          RST_CYCLES = 7;
    localparam int unsigned CYCLE_LIMIT = 100000;
    // result comes in the cycle after accept; the drain wait adds spare margin on top
    localparam int          DRAIN_CYCLES = 4;
    localparam int unsigned PAGE = DEF_PAGE_BYTES;
    localparam int unsigned MAX_PAGES = DEF_MAX_PAGES;
    localparam int          RANDOM_PHASES = 12;
    localparam int          ITEMS_PER_PHASE = 66;
    localparam logic        KERN = 1'b1;
    localparam logic        USER = 1'b0;
    // index with no register behind it; writes must be ignored
    localparam t_cfg_idx    CFG_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] DIR_BASE = 40'h5A_5A5A_5000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd                 i_cmd;
    logic                 i_region_select;
    logic [ADDR_W-1:0]    i_page_addr;
    logic                 o_valid;
    logic [ADDR_W-1:0]    o_out_addr;
    t_status              o_status;
    logic [CNT_W-1:0]     o_free_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    int                   fail_count;
    int                   pending;
    int unsigned          cycle_count = 0;

    // what the stimulus believes the region geometry is
    longint unsigned      cur_base;
    int unsigned          cur_kern;
    int unsigned          cur_user;
    int unsigned          burst_left;

    always #4 i_clk = ~i_clk;

    two_region_page_allocator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_region_select (i_region_select),
        .i_page_addr     (i_page_addr),
        .o_valid         (o_valid),
        .o_out_addr      (o_out_addr),
        .o_status        (o_status),
        .o_free_count    (o_free_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    page_allocator_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_cmd            (i_cmd),
        .i_region_select  (i_region_select),
        .i_page_addr      (i_page_addr),
        .i_res_valid      (o_valid),
        .i_res_addr       (o_out_addr),
        .i_res_status     (o_status),
        .i_res_free_count (o_free_count),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_region_page_allocator_core test failed");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic longint unsigned rand_page_base();
        logic [ADDR_W-1:0] a;
        a = rand_addr();
        a[11:0] = '0;
        return 64'(a);
    endfunction

    // start address and page count of a region under the current config;
    // the user region shrinks to whatever the kernel region leaves
    task automatic region_bounds(input logic kern, output longint unsigned first,
                                 output int unsigned pages);
        int unsigned ksz;
        ksz   = (cur_kern < MAX_PAGES) ? cur_kern : MAX_PAGES;
        first = cur_base;
        if (kern) begin
            pages = ksz;
        end else begin
            first = first + 64'(ksz) * 64'(PAGE);
            pages = (cur_user < MAX_PAGES - ksz) ? cur_user : MAX_PAGES - ksz;
        end
    endtask

    // Sender pacing: bursts of back-to-back commands, then a random gap.
    // A zero gap keeps start high so the next burst follows without a bubble.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(16, 1);
        end
    endtask

    // One command transaction: hold start until an edge sees busy low.
    task automatic send_cmd(input t_cmd cmd, input logic kern,
                            input logic [ADDR_W-1:0] addr);
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_region_select <= kern;
        i_page_addr     <= addr;
        do @(posedge i_clk); while (busy);
        pace();
    endtask

    // Config write transaction; valid stays high across back-to-back writes.
    task automatic cfg_write(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes all three registers. Size writes carry junk above bit 12,
    // which the block has to drop.
    task automatic set_geometry(input longint unsigned base, input int unsigned kp,
                                input int unsigned up);
        logic [ADDR_W-1:0] data;
        logic [63:0]       base_bits;
        logic [31:0]       kp_bits;
        logic [31:0]       up_bits;
        base_bits = base;
        kp_bits   = kp;
        up_bits   = up;
        cfg_write(CFG_BASE_ADDR, base_bits[ADDR_W-1:0]);
        data = rand_addr();
        data[CNT_W-1:0] = kp_bits[CNT_W-1:0];
        cfg_write(CFG_KERN_PAGES, data);
        data = rand_addr();
        data[CNT_W-1:0] = up_bits[CNT_W-1:0];
        cfg_write(CFG_USER_PAGES, data);
        i_cfg_valid <= 1'b0;
        cur_base = base_bits[ADDR_W-1:0];
        cur_kern = kp;
        cur_user = up;
    endtask

    // Block is idle once every expected result is in; the checker's count is
    // registered, so look only after the last accept has been clocked in.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Mostly well-formed traffic: allocs and frees of pages that lie inside
    // the region, so stacks fill and drain and both limits get hit. The rest
    // are bad frees, inits, no-ops and fully random addresses.
    task automatic random_item();
        int unsigned     pick;
        int unsigned     pages;
        logic            kern;
        longint unsigned first;
        longint unsigned addr;
        logic [63:0]     bits;
        kern = 1'($urandom_range(1));
        region_bounds(kern, first, pages);
        pick = $urandom_range(99);
        addr = 64'(rand_addr());
        if (pick < 45) begin
            // page_addr is don't-care on alloc; random content anyway
            send_cmd(CMD_ALLOC, kern, addr[ADDR_W-1:0]);
        end else if (pick < 80) begin
            if (pages > 0) begin
                addr = first + 64'($urandom_range(pages - 1)) * 64'(PAGE);
            end
            bits = addr;
            send_cmd(CMD_FREE, kern, bits[ADDR_W-1:0]);
        end else if (pick < 86) begin
            addr = first + 64'($urandom_range(PAGE - 1, 1));
            if (pages > 0) begin
                addr = addr + 64'($urandom_range(pages - 1)) * 64'(PAGE);
            end
            bits = addr;
            send_cmd(CMD_FREE, kern, bits[ADDR_W-1:0]);
        end else if (pick < 92) begin
            // just past the end, one page below the start, or anywhere
            case ($urandom_range(2))
                0: addr = first + 64'(pages) * 64'(PAGE);
                1: addr = first - 64'(PAGE);
                default: ;
            endcase
            bits = addr;
            send_cmd(CMD_FREE, kern, bits[ADDR_W-1:0]);
        end else if (pick < 95) begin
            send_cmd(CMD_INIT, kern, addr[ADDR_W-1:0]);
        end else if (pick < 98) begin
            send_cmd(CMD_NOP, kern, addr[ADDR_W-1:0]);
        end else begin
            send_cmd(CMD_FREE, kern, addr[ADDR_W-1:0]);
        end
    endtask

    initial begin
        longint unsigned base;
        int unsigned     kp;
        int unsigned     up;

        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cmd           <= CMD_NOP;
        i_region_select <= 1'b0;
        i_page_addr     <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_BASE_ADDR;
        i_cfg_data      <= '0;
        cur_base   = 0;
        cur_kern   = RST_KERN_PAGES;
        cur_user   = RST_USER_PAGES;
        burst_left = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset geometry: kernel [0, 4 MiB), user above it.
        send_cmd(CMD_ALLOC, KERN, '0);
        send_cmd(CMD_ALLOC, USER, '1);
        send_cmd(CMD_FREE,  KERN, '0);
        // second free of the same page: nothing left out to take back
        send_cmd(CMD_FREE,  KERN, '0);
        send_cmd(CMD_FREE,  KERN, '1);
        send_cmd(CMD_FREE,  KERN, 40'(1024 * PAGE));
        send_cmd(CMD_FREE,  USER, 40'hFF_FFFF_F000);
        send_cmd(CMD_NOP,   KERN, '0);
        send_cmd(CMD_INIT,  USER, '0);
        send_cmd(CMD_FREE,  USER, 40'(1024 * PAGE));
        wait_idle();

        // Directed, tiny regions: two kernel pages, one user page.
        set_geometry(64'(DIR_BASE), 2, 1);
        send_cmd(CMD_INIT,  KERN, '0);
        send_cmd(CMD_ALLOC, KERN, '0);
        send_cmd(CMD_ALLOC, KERN, '0);
        send_cmd(CMD_ALLOC, KERN, '0);
        send_cmd(CMD_ALLOC, USER, '0);
        send_cmd(CMD_ALLOC, USER, '0);
        send_cmd(CMD_FREE,  KERN, DIR_BASE);
        send_cmd(CMD_FREE,  KERN, DIR_BASE + 40'(PAGE));
        send_cmd(CMD_FREE,  KERN, DIR_BASE);
        // LIFO: last freed page comes back first
        send_cmd(CMD_ALLOC, KERN, '0);
        send_cmd(CMD_ALLOC, KERN, '0);
        wait_idle();

        // Shrink the kernel region under a watermark of two, no init:
        // region must read as having no fresh pages left. Stacks are empty
        // here, so no pop can land on a slot that was never written.
        set_geometry(64'(DIR_BASE), 1, 1);
        send_cmd(CMD_ALLOC, KERN, '0);
        send_cmd(CMD_FREE,  KERN, DIR_BASE);
        send_cmd(CMD_ALLOC, KERN, '0);
        wait_idle();

        // Random phases. Each one starts with an init so that stale stack
        // slots from an older geometry are never popped.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            base = rand_page_base();
            kp   = $urandom_range(24, 1);
            up   = $urandom_range(24, 1);
            case (phase)
                0: begin
                    kp = 8;
                    up = 12;
                end
                1: begin
                    base = 0;
                    kp   = 0;
                    up   = MAX_PAGES;
                end
                2: begin
                    // top of the address space, user region squeezed to zero
                    base = 64'h00FF_FFFF_F000;
                    kp   = MAX_PAGES;
                    up   = MAX_PAGES;
                end
                3: begin
                    // base off page alignment
                    base = 64'(rand_addr());
                    kp   = $urandom_range(16, 1);
                    up   = $urandom_range(16, 1);
                end
                4: begin
                    kp = 0;
                    up = 0;
                end
                5: begin
                    kp = RST_KERN_PAGES;
                    up = RST_USER_PAGES;
                end
                default: ;
            endcase
            set_geometry(base, kp, up);
            if (phase == 4) begin
                cfg_write(CFG_UNUSED, rand_addr());
                i_cfg_valid <= 1'b0;
            end
            send_cmd(CMD_INIT, 1'($urandom_range(1)), rand_addr());
            repeat (ITEMS_PER_PHASE) random_item();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("two_region_page_allocator_core test passed");
        end else begin
            $display("two_region_page_allocator_core test failed");
        end
        $finish;
    end

endmodule
